// ===== design/sbr_pkg.sv =====
// Shared types, constants and helper functions for the sampled bitvector rank core.
package sbr_pkg;

  localparam int MAX_WORDS_DEF = 1024;

  localparam int CNT_W     = 17;
  localparam int IDX_W     = 10;
  localparam int WORD_W    = 64;
  localparam int OFF_W     = 6;
  localparam int NW_W      = 11;
  localparam int BLK_W     = 11;
  localparam int POP_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int DEF_BLK   = 8;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_RANK1 = 2'd2,
    CMD_RANK0 = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_LENGTH       = 1'b0,
    REG_WORDS_PER_SAMPLE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_WR,
    S_BUILD_RUN,
    S_BUILD_END,
    S_Q_DIV,
    S_Q_BC,
    S_Q_ACC0,
    S_Q_WORDS
  } state_t;

  typedef struct packed {
    logic             go;
    logic [NW_W-1:0]  dividend;
    logic [BLK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NW_W-1:0]  quotient;
    logic [BLK_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [POP_W-1:0] popcount(logic [WORD_W-1:0] x);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + POP_W'(x[i]);
    end
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] low_mask(logic [OFF_W-1:0] n);
    return ~({WORD_W{1'b1}} << n);
  endfunction

endpackage

// ===== design/sbr_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the block lookup of rank queries.
module sbr_div (
  input  logic              clk,
  input  logic              rst,
  input  sbr_pkg::div_req_t req,
  output sbr_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(sbr_pkg::NW_W + 1);

  logic [sbr_pkg::BLK_W-1:0] rem;
  logic [sbr_pkg::NW_W-1:0]  quo;
  logic [sbr_pkg::BLK_W-1:0] dvs;
  logic [CW-1:0]             cnt;
  logic                      run;
  logic                      done;
  logic [sbr_pkg::BLK_W:0]   sh;
  logic                      fits;

  assign sh   = {rem, quo[sbr_pkg::NW_W-1]};
  assign fits = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CW'(1));
      if (req.go) begin
        run <= 1'b1;
        cnt <= CW'(sbr_pkg::NW_W);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (run) begin
      if (fits) begin
        rem <= sbr_pkg::BLK_W'(sh - {1'b0, dvs});
      end else begin
        rem <= sh[sbr_pkg::BLK_W-1:0];
      end
      quo <= {quo[sbr_pkg::NW_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== design/sampled_bitvector_rank_core.sv =====
// Top level: word store, sampled block counts, build walker and rank query sequencer.
//
//  channel  | ports                                         | transaction
//  ---------+-----------------------------------------------+----------------------------
//  command  | start, busy, command, word_index, word_data,  | start && !busy
//           | position                                      |
//  result   | done, count                                   | done (one cycle, no stall)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data     | cfg_valid && cfg_ready
//
// Load: the word is written in the load-write state. Trivial queries finish from idle.
// Build: one word store read per cycle. Empty length: finishes straight from idle.
// Rank: the divider gives the block and r = (clamped position/64) mod block size;
// then the block count, r whole words and, when the clamped position is not a
// multiple of 64, one partial word are read, one word store read per cycle.
// Reset is synchronous and clears control state only; memories are not cleared.
// The result is held for one cycle on done; the receiver cannot stall it.
module sampled_bitvector_rank_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [sbr_pkg::IDX_W-1:0]     word_index,
  input  logic [sbr_pkg::WORD_W-1:0]    word_data,
  input  logic [sbr_pkg::CNT_W-1:0]     position,
  output logic                          done,
  output logic [sbr_pkg::CNT_W-1:0]     count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbr_pkg::CNT_W-1:0]     cfg_data
);

  localparam int  MAX_WORDS = sbr_pkg::MAX_WORDS_DEF;
  localparam int  AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int  BW        = $clog2(MAX_WORDS + 1);
  localparam logic [31:0] CAP = 32'(MAX_WORDS) * 32'd64;

  localparam int CW = sbr_pkg::CNT_W;
  localparam int NW = sbr_pkg::NW_W;

  // memories
  logic [sbr_pkg::WORD_W-1:0] word_mem [MAX_WORDS];
  logic [CW-1:0]              bc_mem   [MAX_WORDS+1];
  logic [sbr_pkg::WORD_W-1:0] w_rdata;
  logic [CW-1:0]              bc_rdata;

  // control and configuration
  sbr_pkg::state_t         state, state_next;
  logic [CW-1:0]           bit_length;
  logic [sbr_pkg::BLK_W-1:0] words_per_sample;
  logic                    built;
  logic [CW-1:0]           len_l;
  logic [sbr_pkg::BLK_W-1:0] blk_l;

  // datapath
  logic [AW-1:0]              ld_addr;
  logic [sbr_pkg::WORD_W-1:0] ld_data;
  logic [NW-1:0]              nwords;
  logic [NW-1:0]              bw;
  logic [sbr_pkg::BLK_W-1:0]  binblk;
  logic [NW-1:0]              bb;
  logic [CW-1:0]              total;
  logic                       rv;
  logic                       rstart;
  logic                       rlast;
  logic [sbr_pkg::WORD_W-1:0] rmask;
  logic [CW-1:0]              p_l;
  logic                       q_zero;
  logic [NW-1:0]              bq;
  logic [NW-1:0]              wptr;
  logic [sbr_pkg::BLK_W-1:0]  wrem;
  logic                       part;
  logic [CW:0]                acc;

  // combinational
  sbr_pkg::cmd_t            cmd;
  sbr_pkg::div_req_t        div_req;
  sbr_pkg::div_rsp_t        div_rsp;
  logic [CW-1:0]            lenc;
  logic [sbr_pkg::BLK_W-1:0] blk_sel;
  logic [CW-1:0]            pos_clamp;
  logic                     trivial;
  logic [AW-1:0]            w_raddr;
  logic                     w_we;
  logic [BW-1:0]            bc_raddr;
  logic                     bc_we;
  logic [BW-1:0]            bc_waddr;
  logic                     fin;
  logic [CW-1:0]            fin_count;
  logic [sbr_pkg::POP_W-1:0] rpop;
  logic [NW-1:0]            nwords_calc;

  sbr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cmd       = sbr_pkg::cmd_t'(command);
  assign busy      = state != sbr_pkg::S_IDLE;
  assign cfg_ready = 1'b1;

  assign lenc        = ({15'd0, bit_length} > CAP) ? CW'(CAP) : bit_length;
  assign blk_sel     = (words_per_sample == '0) ? sbr_pkg::BLK_W'(sbr_pkg::DEF_BLK)
                                                : words_per_sample;
  assign nwords_calc = NW'(({1'b0, lenc} + (CW+1)'(63)) >> sbr_pkg::OFF_W);
  assign pos_clamp   = (position > len_l) ? len_l : position;
  assign trivial     = !built || (len_l == '0) || (position == '0);
  assign rpop        = sbr_pkg::popcount(w_rdata & rmask);

  always_comb begin
    state_next = state;
    div_req    = '0;
    w_raddr    = AW'(bw);
    w_we       = 1'b0;
    bc_raddr   = BW'(bq);
    bc_we      = 1'b0;
    bc_waddr   = BW'(bb);
    fin        = 1'b0;
    fin_count  = '0;
    unique case (state)
      sbr_pkg::S_IDLE: begin
        if (start) begin
          unique case (cmd) inside
            sbr_pkg::CMD_LOAD: begin
              state_next = sbr_pkg::S_LOAD_WR;
            end
            sbr_pkg::CMD_BUILD: begin
              if (lenc == '0) begin
                fin = 1'b1;
              end else begin
                state_next = sbr_pkg::S_BUILD_RUN;
              end
            end
            sbr_pkg::CMD_RANK1, sbr_pkg::CMD_RANK0: begin
              if (trivial) begin
                fin = 1'b1;
              end else begin
                div_req.go       = 1'b1;
                div_req.dividend = pos_clamp[CW-1:sbr_pkg::OFF_W];
                div_req.divisor  = blk_l;
                state_next       = sbr_pkg::S_Q_DIV;
              end
            end
          endcase
        end
      end
      sbr_pkg::S_LOAD_WR: begin
        w_we       = 1'b1;
        fin        = 1'b1;
        state_next = sbr_pkg::S_IDLE;
      end
      sbr_pkg::S_BUILD_RUN: begin
        w_raddr = AW'(bw);
        bc_we   = rv && rstart;
        if (rv && rlast) begin
          state_next = sbr_pkg::S_BUILD_END;
        end
      end
      sbr_pkg::S_BUILD_END: begin
        bc_we      = 1'b1;
        fin        = 1'b1;
        state_next = sbr_pkg::S_IDLE;
      end
      sbr_pkg::S_Q_DIV: begin
        if (div_rsp.done) begin
          state_next = sbr_pkg::S_Q_BC;
        end
      end
      sbr_pkg::S_Q_BC: begin
        bc_raddr   = BW'(bq);
        state_next = sbr_pkg::S_Q_ACC0;
      end
      sbr_pkg::S_Q_ACC0: begin
        state_next = sbr_pkg::S_Q_WORDS;
      end
      sbr_pkg::S_Q_WORDS: begin
        w_raddr = AW'(wptr);
        if ((wrem == '0) && !part && !rv) begin
          fin = 1'b1;
          if (q_zero) begin
            fin_count = ({1'b0, p_l} >= acc) ? CW'({1'b0, p_l} - acc) : '0;
          end else begin
            fin_count = acc[CW-1:0];
          end
          state_next = sbr_pkg::S_IDLE;
        end
      end
      default: state_next = sbr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration and latched build parameters
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_length       <= '0;
      words_per_sample <= '0;
      built            <= 1'b0;
      len_l            <= '0;
      blk_l            <= sbr_pkg::BLK_W'(sbr_pkg::DEF_BLK);
      done             <= 1'b0;
      count            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (sbr_pkg::cfg_reg_t'(cfg_index))
          sbr_pkg::REG_BIT_LENGTH:       bit_length       <= cfg_data;
          sbr_pkg::REG_WORDS_PER_SAMPLE: words_per_sample <= cfg_data[sbr_pkg::BLK_W-1:0];
        endcase
      end
      if ((state == sbr_pkg::S_IDLE) && start && (cmd == sbr_pkg::CMD_BUILD)) begin
        built <= 1'b1;
        len_l <= lenc;
        blk_l <= blk_sel;
      end
      done <= fin;
      if (fin) begin
        count <= fin_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      unique case (state)
        sbr_pkg::S_BUILD_RUN: rv <= bw != nwords;
        sbr_pkg::S_Q_WORDS:   rv <= (wrem != '0) || part;
        default:              rv <= 1'b0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      sbr_pkg::S_IDLE: begin
        ld_data <= word_data;
        ld_addr <= AW'(word_index);
        nwords  <= nwords_calc;
        bw      <= '0;
        binblk  <= '0;
        bb      <= '0;
        total   <= '0;
        p_l     <= pos_clamp;
        q_zero  <= cmd == sbr_pkg::CMD_RANK0;
      end
      sbr_pkg::S_BUILD_RUN: begin
        if (bw != nwords) begin
          rstart <= binblk == '0;
          rlast  <= bw == NW'(nwords - NW'(1));
          if ((bw == NW'(nwords - NW'(1))) && (len_l[sbr_pkg::OFF_W-1:0] != '0)) begin
            rmask <= sbr_pkg::low_mask(len_l[sbr_pkg::OFF_W-1:0]);
          end else begin
            rmask <= '1;
          end
          bw     <= NW'(bw + NW'(1));
          binblk <= (sbr_pkg::BLK_W'(binblk + sbr_pkg::BLK_W'(1)) == blk_l) ? '0
                    : sbr_pkg::BLK_W'(binblk + sbr_pkg::BLK_W'(1));
        end
        if (rv) begin
          if (rstart) begin
            bb <= NW'(bb + NW'(1));
          end
          total <= CW'(total + CW'(rpop));
        end
      end
      sbr_pkg::S_Q_DIV: begin
        if (div_rsp.done) begin
          bq   <= div_rsp.quotient;
          wptr <= NW'(p_l[CW-1:sbr_pkg::OFF_W] - NW'(div_rsp.remainder));
          wrem <= div_rsp.remainder;
          part <= p_l[sbr_pkg::OFF_W-1:0] != '0;
        end
      end
      sbr_pkg::S_Q_ACC0: begin
        acc <= {1'b0, bc_rdata};
      end
      sbr_pkg::S_Q_WORDS: begin
        if (wrem != '0) begin
          rmask <= '1;
          wptr  <= NW'(wptr + NW'(1));
          wrem  <= sbr_pkg::BLK_W'(wrem - sbr_pkg::BLK_W'(1));
        end else if (part) begin
          rmask <= sbr_pkg::low_mask(p_l[sbr_pkg::OFF_W-1:0]);
          part  <= 1'b0;
        end
        if (rv) begin
          acc <= (CW+1)'(acc + (CW+1)'(rpop));
        end
      end
      default: begin
      end
    endcase
  end

  // word store
  always_ff @(posedge clk) begin
    if (w_we) begin
      word_mem[ld_addr] <= ld_data;
    end
    w_rdata <= word_mem[w_raddr];
  end

  // sampled block counts
  always_ff @(posedge clk) begin
    if (bc_we) begin
      bc_mem[bc_waddr] <= total;
    end
    bc_rdata <= bc_mem[bc_raddr];
  end

endmodule

// ===== tb/sampled_bitvector_rank_core_tb.sv =====
// Self-checking testbench for sampled_bitvector_rank_core: loads, builds and rank queries.
module sampled_bitvector_rank_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP_BITS  = 65536;
  localparam int unsigned N_ITEMS   = 750;
  localparam int unsigned SETTLE    = 4;
  localparam int unsigned IDLE_MAX  = 10000;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_t;

  typedef struct {
    act_t                      kind;
    int unsigned               gap;
    sbr_pkg::cmd_t             cmd;
    logic [sbr_pkg::IDX_W-1:0] idx;
    logic [63:0]               data;
    logic [16:0]               pos;
    sbr_pkg::cfg_reg_t         sel;
    logic [16:0]               val;
  } op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = '0;
  logic [sbr_pkg::IDX_W-1:0]     word_index = '0;
  logic [sbr_pkg::WORD_W-1:0]    word_data = '0;
  logic [sbr_pkg::CNT_W-1:0]     position = '0;
  logic        done;
  logic [sbr_pkg::CNT_W-1:0]     count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [sbr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sbr_pkg::CNT_W-1:0]     cfg_data = '0;

  sampled_bitvector_rank_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .word_index(word_index), .word_data(word_data), .position(position),
    .done(done), .count(count), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the block state
  logic [63:0]  word_mem [1024];
  logic [16:0]  blk_ones [1025];
  bit           built = 1'b0;
  logic [16:0]  reg_len = '0;
  logic [10:0]  reg_wps = '0;
  int unsigned  lat_len = 0;
  int unsigned  lat_blk = 8;

  logic [16:0]  pending_counts [$];
  op_t          op_queue [$];
  int unsigned  sent_cnt = 0;
  int unsigned  rcv_cnt = 0;
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;

  bit           in_flight = 1'b0;
  bit           nxt_start, nxt_cfg;
  int unsigned  hold = 0;
  logic [16:0]  want;

  // Generator bookkeeping
  bit           gen_written [1024];
  int unsigned  gen_len = 0;
  int unsigned  gen_lat = 0;
  int unsigned  gen_items = 0;
  bit           no_idle = 1'b0;

  function automatic void sample_blocks();
    int unsigned nwords, nblk, total, stop_w, valid;
    logic [63:0] w;
    lat_len = (reg_len > 17'(CAP_BITS)) ? CAP_BITS : reg_len;
    lat_blk = (reg_wps == 11'd0) ? sbr_pkg::DEF_BLK : reg_wps;
    built = 1'b1;
    if (lat_len == 0) return;
    nwords = (lat_len + 63) / 64;
    nblk = (nwords + lat_blk - 1) / lat_blk;
    total = 0;
    for (int unsigned b = 0; b < nblk; b++) begin
      blk_ones[b] = 17'(total);
      stop_w = (b + 1) * lat_blk;
      if (stop_w > nwords) stop_w = nwords;
      for (int unsigned i = b * lat_blk; i < stop_w; i++) begin
        w = word_mem[i];
        valid = lat_len - i * 64;
        if (valid < 64) w &= (64'd1 << valid) - 64'd1;
        total += $countones(w);
      end
    end
    blk_ones[nblk] = 17'(total);
  endfunction

  function automatic int unsigned ones_before(int unsigned pos);
    int unsigned p, b, ans;
    if (!built || lat_len == 0 || pos == 0) return 0;
    p = (pos > lat_len) ? lat_len : pos;
    b = p / (64 * lat_blk);
    ans = blk_ones[b];
    for (int unsigned i = b * lat_blk; i < p / 64; i++)
      ans += $countones(word_mem[i]);
    if (p % 64 != 0)
      ans += $countones(word_mem[p / 64] & ((64'd1 << (p % 64)) - 64'd1));
    return ans;
  endfunction

  function automatic logic [16:0] rank_count(sbr_pkg::cmd_t c, logic [16:0] pos);
    int unsigned ones, p;
    logic [16:0] r;
    r = '0;
    ones = ones_before(pos);
    if (c == sbr_pkg::CMD_RANK1) begin
      r = 17'(ones);
    end else if (c == sbr_pkg::CMD_RANK0 && built && lat_len != 0) begin
      p = (pos > lat_len) ? lat_len : pos;
      r = (p >= ones) ? 17'(p - ones) : '0;
    end
    return r;
  endfunction

  function automatic void accept_item();
    sbr_pkg::cmd_t c;
    c = sbr_pkg::cmd_t'(command);
    pending_counts.push_back(rank_count(c, position));
    if (c == sbr_pkg::CMD_LOAD) word_mem[word_index] = word_data;
    else if (c == sbr_pkg::CMD_BUILD) sample_blocks();
    sent_cnt++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      in_flight = 1'b0;
      hold = 0;
    end else begin
      nxt_start = start;
      nxt_cfg = cfg_valid;
      if (start && !busy) begin
        accept_item();
        nxt_start = 1'b0;
        in_flight = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sbr_pkg::REG_BIT_LENGTH) reg_len = cfg_data;
        else reg_wps = cfg_data[10:0];
        nxt_cfg = 1'b0;
        in_flight = 1'b0;
      end
      if (!in_flight && op_queue.size() != 0) begin
        case (op_queue[0].kind)
          ACT_ITEM: begin
            if (hold >= op_queue[0].gap) begin
              command <= op_queue[0].cmd;
              word_index <= op_queue[0].idx;
              word_data <= op_queue[0].data;
              position <= op_queue[0].pos;
              nxt_start = 1'b1;
              in_flight = 1'b1;
              hold = 0;
              void'(op_queue.pop_front());
            end else begin
              hold++;
            end
          end
          ACT_CFG: begin
            cfg_index <= op_queue[0].sel;
            cfg_data <= op_queue[0].val;
            nxt_cfg = 1'b1;
            in_flight = 1'b1;
            void'(op_queue.pop_front());
          end
          default: begin
            // wait for every outstanding count and for the core to go idle, then settle
            if (sent_cnt != rcv_cnt || busy) begin
              hold = 0;
            end else if (hold >= SETTLE) begin
              hold = 0;
              void'(op_queue.pop_front());
            end else begin
              hold++;
            end
          end
        endcase
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, actual %0d",
                 $time, count);
        errors++;
      end else begin
        want = pending_counts.pop_front();
        if (count !== want) begin
          $display("%0t: count mismatch, expected %0d, actual %0d", $time, want, count);
          errors++;
        end
        rcv_cnt <= rcv_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_MAX) begin
      $display("%0t: watchdog timeout", $time);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = 64'd1 << $urandom_range(0, 63);
      3: w = ~(64'd1 << $urandom_range(0, 63));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  function automatic logic [16:0] query_pos();
    int unsigned lim;
    logic [16:0] p;
    lim = (gen_lat != 0) ? gen_lat : 300;
    case ($urandom_range(0, 9))
      0: p = '0;
      1: p = 17'(lim);
      2: p = 17'(lim + $urandom_range(1, 64));
      3: p = 17'($urandom);
      4: p = 17'($urandom_range(0, lim / 64) * 64);
      default: p = 17'($urandom_range(0, lim));
    endcase
    return p;
  endfunction

  function automatic void push_item(sbr_pkg::cmd_t c, logic [sbr_pkg::IDX_W-1:0] idx,
                                    logic [63:0] data, logic [16:0] pos);
    op_t o;
    o.kind = ACT_ITEM;
    o.gap = no_idle ? 0 : $urandom_range(0, 3);
    o.cmd = c;
    o.idx = idx;
    o.data = data;
    o.pos = pos;
    o.sel = sbr_pkg::REG_BIT_LENGTH;
    o.val = '0;
    op_queue.push_back(o);
    gen_items++;
    if (c == sbr_pkg::CMD_LOAD) gen_written[idx] = 1'b1;
    if (c == sbr_pkg::CMD_BUILD) gen_lat = (gen_len > CAP_BITS) ? CAP_BITS : gen_len;
  endfunction

  function automatic void push_query(sbr_pkg::cmd_t c, logic [16:0] pos);
    push_item(c, sbr_pkg::IDX_W'($urandom), {$urandom, $urandom}, pos);
  endfunction

  function automatic void push_load(logic [sbr_pkg::IDX_W-1:0] idx, logic [63:0] data);
    push_item(sbr_pkg::CMD_LOAD, idx, data, 17'($urandom));
  endfunction

  // every word a build will read is loaded first
  function automatic void push_build();
    int unsigned need;
    need = (((gen_len > CAP_BITS) ? CAP_BITS : gen_len) + 63) / 64;
    for (int unsigned i = 0; i < need; i++)
      if (!gen_written[i]) push_load(sbr_pkg::IDX_W'(i), rand_word());
    push_query(sbr_pkg::CMD_BUILD, 17'($urandom));
  endfunction

  function automatic void push_drain();
    op_t o;
    o.kind = ACT_DRAIN;
    o.gap = 0;
    op_queue.push_back(o);
  endfunction

  function automatic void push_reg(sbr_pkg::cfg_reg_t sel, logic [16:0] val);
    op_t o;
    o.kind = ACT_CFG;
    o.gap = 0;
    o.sel = sel;
    o.val = val;
    op_queue.push_back(o);
  endfunction

  function automatic void set_regs(int unsigned len, logic [16:0] wps_val);
    push_drain();
    push_reg(sbr_pkg::REG_BIT_LENGTH, 17'(len));
    push_reg(sbr_pkg::REG_WORDS_PER_SAMPLE, wps_val);
    gen_len = len;
  endfunction

  initial begin : stim
    int unsigned len, wps, n, sel, lim;
    logic [16:0] wps_val;

    // queries on an unbuilt and then an empty vector
    push_query(sbr_pkg::CMD_RANK1, 17'd5);
    push_query(sbr_pkg::CMD_RANK0, 17'h1FFFF);
    push_build();
    push_query(sbr_pkg::CMD_RANK0, 17'd77);

    set_regs(200, 17'd0);
    push_load(10'd0, '1);
    push_load(10'd1, '0);
    push_load(10'd2, 64'hAAAA_AAAA_AAAA_AAAA);
    push_load(10'd3, {$urandom, $urandom});
    push_load(10'd1023, '1);
    push_build();
    push_query(sbr_pkg::CMD_RANK1, 17'd0);
    push_query(sbr_pkg::CMD_RANK1, 17'd1);
    push_query(sbr_pkg::CMD_RANK1, 17'd64);
    push_query(sbr_pkg::CMD_RANK1, 17'd130);
    push_query(sbr_pkg::CMD_RANK1, 17'd199);
    push_query(sbr_pkg::CMD_RANK1, 17'd200);
    push_query(sbr_pkg::CMD_RANK1, 17'h1FFFF);
    push_query(sbr_pkg::CMD_RANK0, 17'd150);
    push_query(sbr_pkg::CMD_RANK0, 17'd200);
    push_query(sbr_pkg::CMD_RANK0, 17'h1FFFF);

    // new block size only takes effect at the next build
    set_regs(200, 17'd1);
    push_query(sbr_pkg::CMD_RANK1, 17'd199);
    push_build();
    // reload after build: sampled counts stay stale
    push_load(10'd0, '0);
    push_query(sbr_pkg::CMD_RANK1, 17'd130);
    push_query(sbr_pkg::CMD_RANK0, 17'd130);

    for (int ph = 0; gen_items < N_ITEMS; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case (ph)
        0: begin len = 4096; wps = 1; end
        1: begin len = 8191; wps = 2047; end
        2: begin len = $urandom_range(1, 4096); wps = 1024; end
        3: begin len = 1; wps = 0; end
        default: begin
          case ($urandom_range(0, 9))
            0: len = 0;
            1: len = $urandom_range(1, 64);
            2: len = 64 * $urandom_range(1, 32);
            3: len = $urandom_range(65, 2048);
            4: len = $urandom_range(1, 8192);
            5: len = 8192;
            default: len = $urandom_range(1, 1024);
          endcase
          case ($urandom_range(0, 7))
            0: wps = 0;
            1: wps = 1;
            2: wps = $urandom_range(2, 16);
            3: wps = $urandom_range(17, 1024);
            4: wps = $urandom_range(1025, 2047);
            default: wps = $urandom_range(1, 8);
          endcase
        end
      endcase
      wps_val = 17'(wps);
      if (ph == 1 || $urandom_range(0, 1) == 0) wps_val[16:11] = 6'($urandom);
      if (ph < 4 || $urandom_range(0, 5) != 0) set_regs(len, wps_val);
      if (ph < 4 || $urandom_range(0, 5) != 0) push_build();
      n = $urandom_range(20, 50);
      for (int k = 0; k < n && gen_items < N_ITEMS; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          lim = (gen_lat + 63) / 64 + 2;
          if (lim > 1024) lim = 1024;
          if ($urandom_range(0, 3) == 0) push_load(sbr_pkg::IDX_W'($urandom), rand_word());
          else push_load(sbr_pkg::IDX_W'($urandom_range(0, lim - 1)), rand_word());
        end else if (sel < 20) begin
          push_build();
        end else if (sel < 23) begin
          push_drain();
        end else begin
          push_query(($urandom_range(0, 1) == 0) ? sbr_pkg::CMD_RANK1 : sbr_pkg::CMD_RANK0,
                     query_pos());
        end
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (op_queue.size() != 0 || in_flight || start || cfg_valid || sent_cnt != rcv_cnt)
      @(negedge clk);
    repeat (20) @(negedge clk);

    if (pending_counts.size() != 0) begin
      $display("%0t: %0d transactions never returned a count", $time, pending_counts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sbr_pkg.sv
design/sbr_div.sv
design/sampled_bitvector_rank_core.sv
tb/sampled_bitvector_rank_core_tb.sv
